/* hdl/sfd_pkg.sv */
// Shared types, constants and codes for the SLIP frame decoder.
`default_nettype none

package sfd_pkg;

    localparam int BUF_DEPTH_DEF = 64;

    localparam int BYTE_W = 8;
    localparam int WP_W   = 6;
    localparam int POS_W  = 7;
    localparam int LIM_W  = 7;
    localparam int KIND_W = 2;
    localparam int ERR_W  = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_KEEPS    = 2'd1;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [LIM_W-1:0] LIMIT_MIN   = 7'd2;
    localparam logic [POS_W-1:0] POS_SAT     = 7'd127;

    localparam logic [BYTE_W-1:0] SYM_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] SYM_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] SYM_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] SYM_ESC_ESC = 8'hDD;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ESCAPE   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_SEND
    } state_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_OVF,
        RES_ESC_ERR,
        RES_EMPTY,
        RES_FRAME
    } res_sel_t;

    typedef struct packed {
        logic     load_byte;
        res_sel_t emit;
        logic     emit_last;
        logic     clear;
        logic     count;
        logic     store;
        logic     set_pending;
        logic     clr_pending;
        logic     start_drain;
        logic     rd_advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ovf;
        logic pending;
        logic byte_end;
        logic byte_esc;
        logic esc_ok;
        logic frame_empty;
        logic keep;
        logic out_free;
        logic drain_last;
    } dp_sts_t;

endpackage

`default_nettype wire

/* hdl/sfd_channels.sv */
// Handshake channel interfaces: received bytes, decoded results, register writes.
`default_nettype none

interface sfd_rx_if;
    logic                             valid;
    logic                             ready;
    logic [sfd_pkg::BYTE_W-1:0]       rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_tx_if;
    logic                             valid;
    logic                             ready;
    logic [sfd_pkg::KIND_W-1:0]       kind;
    logic [sfd_pkg::BYTE_W-1:0]       frame_byte;
    logic                             last_of_run;
    logic [sfd_pkg::WP_W-1:0]         frame_length;
    logic [sfd_pkg::ERR_W-1:0]        error_code;
    logic [sfd_pkg::POS_W-1:0]        error_position;

    modport source (output valid, output kind, output frame_byte, output last_of_run,
                    output frame_length, output error_code, output error_position,
                    input ready);
    modport sink   (input valid, input kind, input frame_byte, input last_of_run,
                    input frame_length, input error_code, input error_position,
                    output ready);
endinterface

interface sfd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sfd_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [sfd_pkg::CFG_DATA_W-1:0]   wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* hdl/slip_frame_decoder.sv */
// SLIP frame decoder top level: sequencer plus datapath.
//
//  channel | dir | handshake     | payload
//  rx      | in  | valid/ready   | rx_byte
//  tx      | out | valid/ready   | kind, frame_byte, last_of_run, frame_length,
//          |     |               | error_code, error_position
//  cfg     | in  | valid/ready   | reg_index, wdata (ready always high)
//
// A plain or escape byte is accepted in IDLE and decoded in EVAL; an overflow in keep mode adds a second EVAL pass.
// END with buffered bytes then passes READ and SEND for each byte: each byte needs one registered buffer read.
// Reset is asynchronous and clears all control state; the buffer needs no clearing pass.
// Results leave through an output register; the next byte is taken while one waits there.
// A stalled tx side holds the sequencer only when a new result has to be loaded.
`default_nettype none

module slip_frame_decoder #(
    parameter int BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfd_rx_if.sink     rx,
    sfd_tx_if.source   tx,
    sfd_cfg_if.sink    cfg
);

    sfd_pkg::ctrl_cmd_t cmd;
    sfd_pkg::dp_sts_t   sts;
    logic               in_ready;

    assign rx.ready  = in_ready;
    assign cfg.ready = 1'b1;

    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfd_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .rx_byte           (rx.rx_byte),
        .cfg_valid         (cfg.valid),
        .cfg_reg_index     (cfg.reg_index),
        .cfg_wdata         (cfg.wdata),
        .tx_ready          (tx.ready),
        .tx_valid          (tx.valid),
        .tx_kind           (tx.kind),
        .tx_frame_byte     (tx.frame_byte),
        .tx_last_of_run    (tx.last_of_run),
        .tx_frame_length   (tx.frame_length),
        .tx_error_code     (tx.error_code),
        .tx_error_position (tx.error_position)
    );

endmodule

`default_nettype wire

/* hdl/sfd_ctrl.sv */
// Decoder sequencer: accepts a byte, decides its action, drains frames on END.
`default_nettype none

module sfd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sfd_pkg::dp_sts_t   sts,
    output sfd_pkg::ctrl_cmd_t      cmd
);

    sfd_pkg::state_t state_reg;
    sfd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sfd_pkg::ST_EVAL;
                end
            end
            sfd_pkg::ST_EVAL:
            begin
                if (sts.ovf)
                begin
                    if (sts.out_free)
                    begin
                        // keep mode decodes the byte again on the cleared frame
                        state_next = sts.keep ? sfd_pkg::ST_EVAL : sfd_pkg::ST_IDLE;
                    end
                end
                else if (sts.pending)
                begin
                    if (sts.esc_ok || sts.out_free)
                    begin
                        state_next = sfd_pkg::ST_IDLE;
                    end
                end
                else if (sts.byte_end)
                begin
                    if (!sts.frame_empty)
                    begin
                        state_next = sfd_pkg::ST_READ;
                    end
                    else if (sts.out_free)
                    begin
                        state_next = sfd_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = sfd_pkg::ST_IDLE;
                end
            end
            sfd_pkg::ST_READ:
            begin
                state_next = sfd_pkg::ST_SEND;
            end
            sfd_pkg::ST_SEND:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.drain_last ? sfd_pkg::ST_IDLE : sfd_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = sfd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.emit = sfd_pkg::RES_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            sfd_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_byte = in_valid;
            end
            sfd_pkg::ST_EVAL:
            begin
                if (sts.ovf)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = sfd_pkg::RES_OVF;
                        // in keep mode only a following END adds a result
                        cmd.emit_last = !sts.keep || !sts.byte_end;
                        cmd.clear     = 1'b1;
                    end
                end
                else if (sts.pending)
                begin
                    if (sts.esc_ok)
                    begin
                        cmd.store       = 1'b1;
                        cmd.clr_pending = 1'b1;
                        cmd.count       = 1'b1;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.emit      = sfd_pkg::RES_ESC_ERR;
                        cmd.emit_last = 1'b1;
                        cmd.clear     = 1'b1;
                        cmd.count     = sts.keep;
                    end
                end
                else if (sts.byte_end)
                begin
                    if (!sts.frame_empty)
                    begin
                        cmd.start_drain = 1'b1;
                        cmd.clear       = 1'b1;
                        cmd.count       = 1'b1;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.emit      = sfd_pkg::RES_EMPTY;
                        cmd.emit_last = 1'b1;
                        cmd.clear     = 1'b1;
                        cmd.count     = 1'b1;
                    end
                end
                else if (sts.byte_esc)
                begin
                    cmd.set_pending = 1'b1;
                    cmd.count       = 1'b1;
                end
                else
                begin
                    cmd.store = 1'b1;
                    cmd.count = 1'b1;
                end
            end
            sfd_pkg::ST_READ:
            begin
                cmd.emit = sfd_pkg::RES_NONE;
            end
            sfd_pkg::ST_SEND:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = sfd_pkg::RES_FRAME;
                    cmd.emit_last  = sts.drain_last;
                    cmd.rd_advance = 1'b1;
                end
            end
            default:
            begin
                cmd.emit = sfd_pkg::RES_NONE;
            end
        endcase
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != sfd_pkg::RES_NONE) |-> sts.out_free)
        else $error("result loaded while output register is occupied");

    a_drop_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfd_pkg::ST_EVAL && sts.ovf && !sts.keep && sts.out_free)
        |=> (state_reg == sfd_pkg::ST_IDLE))
        else $error("overflow in drop mode did not end the item");

    a_second_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfd_pkg::ST_EVAL && sts.ovf && sts.out_free)
        |=> !sts.ovf && !sts.pending)
        else $error("frame not cleared after overflow");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfd_pkg::ST_SEND && sts.out_free && sts.drain_last)
        |=> (state_reg == sfd_pkg::ST_IDLE))
        else $error("frame drain ran past its last byte");

endmodule

`default_nettype wire

/* hdl/sfd_datapath.sv */
// Decoder datapath: config registers, frame state, frame buffer and output register.
`default_nettype none

module sfd_datapath #(
    parameter int BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire sfd_pkg::ctrl_cmd_t               cmd,
    output sfd_pkg::dp_sts_t                      sts,
    input  wire logic [sfd_pkg::BYTE_W-1:0]       rx_byte,
    input  wire logic                             cfg_valid,
    input  wire logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_reg_index,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             tx_ready,
    output logic                                  tx_valid,
    output logic [sfd_pkg::KIND_W-1:0]            tx_kind,
    output logic [sfd_pkg::BYTE_W-1:0]            tx_frame_byte,
    output logic                                  tx_last_of_run,
    output logic [sfd_pkg::WP_W-1:0]              tx_frame_length,
    output logic [sfd_pkg::ERR_W-1:0]             tx_error_code,
    output logic [sfd_pkg::POS_W-1:0]             tx_error_position
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam logic [sfd_pkg::LIM_W-1:0] DEPTH_LIM = sfd_pkg::LIM_W'(BUF_DEPTH);

    logic [sfd_pkg::LIM_W-1:0]  limit_reg;
    logic                       keep_reg;
    logic [sfd_pkg::BYTE_W-1:0] byte_reg;
    logic [sfd_pkg::WP_W-1:0]   wp_reg;
    logic [sfd_pkg::WP_W-1:0]   wp_next;
    logic                       pending_reg;
    logic                       pending_next;
    logic [sfd_pkg::POS_W-1:0]  bsr_reg;
    logic [sfd_pkg::POS_W-1:0]  bsr_next;
    logic [sfd_pkg::POS_W-1:0]  bsr_base;
    logic [sfd_pkg::WP_W-1:0]   len_reg;
    logic [sfd_pkg::WP_W-1:0]   rd_cnt_reg;
    logic [sfd_pkg::WP_W-1:0]   rd_cnt_next;
    logic [sfd_pkg::BYTE_W-1:0] rdata_reg;
    logic [sfd_pkg::LIM_W-1:0]  limit_eff;
    logic [sfd_pkg::BYTE_W-1:0] store_val;
    logic                       tx_valid_reg;
    logic                       tx_valid_next;
    logic [sfd_pkg::KIND_W-1:0] kind_reg;
    logic [sfd_pkg::BYTE_W-1:0] fbyte_reg;
    logic                       last_reg;
    logic [sfd_pkg::WP_W-1:0]   flen_reg;
    logic [sfd_pkg::ERR_W-1:0]  err_reg;
    logic [sfd_pkg::POS_W-1:0]  epos_reg;

    logic [sfd_pkg::BYTE_W-1:0] mem [BUF_DEPTH];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= sfd_pkg::LIMIT_RESET;
            keep_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_index)
                sfd_pkg::CFG_BUFFER_LIMIT:   limit_reg <= cfg_wdata;
                sfd_pkg::CFG_OVERFLOW_KEEPS: keep_reg  <= cfg_wdata[0];
                default:                     limit_reg <= limit_reg;
            endcase
        end
    end

    // clamp the limit to [2, BUF_DEPTH]
    always_comb
    begin
        if (limit_reg > DEPTH_LIM)
        begin
            limit_eff = DEPTH_LIM;
        end
        else if (limit_reg < sfd_pkg::LIMIT_MIN)
        begin
            limit_eff = sfd_pkg::LIMIT_MIN;
        end
        else
        begin
            limit_eff = limit_reg;
        end
    end

    always_comb
    begin
        if (pending_reg)
        begin
            store_val = (byte_reg == sfd_pkg::SYM_ESC_END) ? sfd_pkg::SYM_END
                                                           : sfd_pkg::SYM_ESC;
        end
        else
        begin
            store_val = byte_reg;
        end
    end

    always_comb
    begin
        wp_next = wp_reg;
        if (cmd.clear)
        begin
            wp_next = '0;
        end
        else if (cmd.store)
        begin
            wp_next = wp_reg + 1'b1;
        end

        pending_next = pending_reg;
        if (cmd.clear || cmd.clr_pending)
        begin
            pending_next = 1'b0;
        end
        else if (cmd.set_pending)
        begin
            pending_next = 1'b1;
        end

        // count applies after any clear of the same step
        bsr_base = cmd.clear ? '0 : bsr_reg;
        bsr_next = bsr_base;
        if (cmd.count && bsr_base < sfd_pkg::POS_SAT)
        begin
            bsr_next = bsr_base + 1'b1;
        end

        rd_cnt_next = rd_cnt_reg;
        if (cmd.start_drain)
        begin
            rd_cnt_next = '0;
        end
        else if (cmd.rd_advance)
        begin
            rd_cnt_next = rd_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            pending_reg <= 1'b0;
            bsr_reg     <= '0;
            len_reg     <= '0;
            rd_cnt_reg  <= '0;
        end
        else
        begin
            wp_reg      <= wp_next;
            pending_reg <= pending_next;
            bsr_reg     <= bsr_next;
            rd_cnt_reg  <= rd_cnt_next;
            if (cmd.start_drain)
            begin
                len_reg <= wp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            byte_reg <= rx_byte;
        end
    end

    // frame buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[wp_reg[AW-1:0]] <= store_val;
        end
        rdata_reg <= mem[rd_cnt_reg[AW-1:0]];
    end

    // output register
    always_comb
    begin
        tx_valid_next = tx_valid_reg;
        if (cmd.emit != sfd_pkg::RES_NONE)
        begin
            tx_valid_next = 1'b1;
        end
        else if (tx_ready)
        begin
            tx_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != sfd_pkg::RES_NONE)
        begin
            last_reg  <= cmd.emit_last;
            kind_reg  <= sfd_pkg::KIND_STATUS;
            fbyte_reg <= '0;
            flen_reg  <= '0;
            err_reg   <= sfd_pkg::ERR_NONE;
            epos_reg  <= '0;
            unique case (cmd.emit)
                sfd_pkg::RES_OVF:
                begin
                    err_reg  <= sfd_pkg::ERR_OVERFLOW;
                    epos_reg <= bsr_reg;
                end
                sfd_pkg::RES_ESC_ERR:
                begin
                    err_reg  <= sfd_pkg::ERR_ESCAPE;
                    epos_reg <= bsr_reg;
                end
                sfd_pkg::RES_EMPTY:
                begin
                    kind_reg <= sfd_pkg::KIND_EMPTY;
                end
                sfd_pkg::RES_FRAME:
                begin
                    kind_reg  <= sfd_pkg::KIND_BYTE;
                    fbyte_reg <= rdata_reg;
                    flen_reg  <= len_reg;
                end
                default:
                begin
                    kind_reg <= sfd_pkg::KIND_STATUS;
                end
            endcase
        end
    end

    always_comb
    begin
        sts.ovf         = ({1'b0, wp_reg} + sfd_pkg::LIMIT_MIN) > limit_eff;
        sts.pending     = pending_reg;
        sts.byte_end    = (byte_reg == sfd_pkg::SYM_END);
        sts.byte_esc    = (byte_reg == sfd_pkg::SYM_ESC);
        sts.esc_ok      = (byte_reg == sfd_pkg::SYM_ESC_END)
                          || (byte_reg == sfd_pkg::SYM_ESC_ESC);
        sts.frame_empty = (wp_reg == '0);
        sts.keep        = keep_reg;
        sts.out_free    = !tx_valid_reg || tx_ready;
        sts.drain_last  = (sfd_pkg::WP_W'(rd_cnt_reg + 1'b1) == len_reg);
    end

    assign tx_valid          = tx_valid_reg;
    assign tx_kind           = kind_reg;
    assign tx_frame_byte     = fbyte_reg;
    assign tx_last_of_run    = last_reg;
    assign tx_frame_length   = flen_reg;
    assign tx_error_code     = err_reg;
    assign tx_error_position = epos_reg;

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> ({1'b0, wp_reg} < DEPTH_LIM))
        else $error("frame buffer written beyond its depth");

endmodule

`default_nettype wire

/* tb/sfd_result_checker.sv */
// Result checker for the SLIP frame decoder: tracks its decode state and compares every result beat.
module sfd_result_checker
    import sfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sfd_rx_if    rx,
    sfd_tx_if    tx,
    sfd_cfg_if   cfg,
    output int   expected_left,
    output int   mismatches
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] frame_byte;
        logic              last_of_run;
        logic [WP_W-1:0]   frame_length;
        logic [ERR_W-1:0]  error_code;
        logic [POS_W-1:0]  error_position;
    } sfd_result_t;

    sfd_result_t       pending_results[$];
    sfd_result_t       want;
    logic [BYTE_W-1:0] frame_mem [BUF_DEPTH_DEF];
    logic [WP_W-1:0]   wr_pos;
    logic              esc_armed;
    logic [POS_W-1:0]  since_clear;
    logic [LIM_W-1:0]  buffer_limit;
    logic              keep_byte;
    int                err_count;

    function automatic void clear_frame();
        wr_pos      = '0;
        esc_armed   = 1'b0;
        since_clear = '0;
    endfunction

    function automatic void store_byte(input logic [BYTE_W-1:0] b);
        frame_mem[wr_pos] = b;
        wr_pos            = wr_pos + 1'b1;
    endfunction

    // position is taken before the frame is cleared
    function automatic sfd_result_t status_result(input logic [ERR_W-1:0] code);
        sfd_result_t r;
        r                = '0;
        r.kind           = KIND_STATUS;
        r.error_code     = code;
        r.error_position = since_clear;
        return r;
    endfunction

    function automatic void decode_slip_byte(input logic [BYTE_W-1:0] c);
        sfd_result_t run[$];
        sfd_result_t r;
        int          lim;
        bit          stop;
        lim  = int'(buffer_limit);
        stop = 1'b0;
        if (lim > BUF_DEPTH_DEF)
            lim = BUF_DEPTH_DEF;
        if (lim < int'(LIMIT_MIN))
            lim = int'(LIMIT_MIN);

        if (int'(wr_pos) + 2 > lim)
        begin
            run.push_back(status_result(ERR_OVERFLOW));
            clear_frame();
            stop = !keep_byte;
        end

        if (!stop)
        begin
            if (esc_armed)
            begin
                esc_armed = 1'b0;
                if (c == SYM_ESC_END)
                    store_byte(SYM_END);
                else if (c == SYM_ESC_ESC)
                    store_byte(SYM_ESC);
                else
                begin
                    run.push_back(status_result(ERR_ESCAPE));
                    clear_frame();
                    stop = !keep_byte;
                end
            end
            else if (c == SYM_END)
            begin
                if (wr_pos == '0)
                begin
                    r      = '0;
                    r.kind = KIND_EMPTY;
                    run.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < int'(wr_pos); i++)
                    begin
                        r              = '0;
                        r.kind         = KIND_BYTE;
                        r.frame_byte   = frame_mem[i];
                        r.frame_length = wr_pos;
                        run.push_back(r);
                    end
                end
                clear_frame();
            end
            else if (c == SYM_ESC)
                esc_armed = 1'b1;
            else
                store_byte(c);
        end

        // counted after any clear, so an END leaves the counter at one
        if (!stop && since_clear != POS_SAT)
            since_clear = since_clear + 1'b1;

        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[k])
            pending_results.push_back(run[k]);
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            err_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            clear_frame();
            buffer_limit  = LIMIT_RESET;
            keep_byte     = 1'b0;
            err_count     = 0;
            expected_left <= 0;
            mismatches    <= 0;
        end
        else
        begin
            if (tx.valid && tx.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected, kind %0d", tx.kind);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, tx.kind);
                    check_field("frame_byte", want.frame_byte, tx.frame_byte);
                    check_field("last_of_run", want.last_of_run, tx.last_of_run);
                    check_field("frame_length", want.frame_length, tx.frame_length);
                    check_field("error_code", want.error_code, tx.error_code);
                    check_field("error_position", want.error_position, tx.error_position);
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    CFG_BUFFER_LIMIT:   buffer_limit = cfg.wdata;
                    CFG_OVERFLOW_KEEPS: keep_byte    = cfg.wdata[0];
                    default: ;
                endcase
            end

            if (rx.valid && rx.ready)
                decode_slip_byte(rx.rx_byte);

            expected_left <= pending_results.size();
            mismatches    <= err_count;
        end
    end

endmodule

/* tb/slip_frame_decoder_tb.sv */
// Testbench top for the SLIP frame decoder: stimulus, handshake idling and the verdict.
module slip_frame_decoder_tb;
    import sfd_pkg::*;

    localparam int RUN_LIMIT   = 300000;
    localparam int DRAIN_TAIL  = 16;
    localparam int IDLE_PCT    = 12;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_BEATS = 25;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   quiet   = 1'b0;
    bit   rx_high = 1'b0;
    int   expected_left;
    int   mismatches;
    int   cycles = 0;
    int   sent   = 0;

    logic [LIM_W-1:0] phase_limit [NUM_PHASES] = '{7'd64, 7'd127, 7'd0, 7'd6, 7'd20, 7'd1, 7'd64};
    bit               phase_keep  [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    sfd_rx_if  rx_if ();
    sfd_tx_if  tx_if ();
    sfd_cfg_if cfg_if ();

    slip_frame_decoder u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if),
        .cfg   (cfg_if)
    );

    sfd_result_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_if),
        .tx            (tx_if),
        .cfg           (cfg_if),
        .expected_left (expected_left),
        .mismatches    (mismatches)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        tx_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tx_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic put_raw(input logic [BYTE_W-1:0] b);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        rx_high = 1'b1;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        sent++;
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            rx_if.valid <= 1'b0;
            rx_high = 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // well-formed frame: content escaped as needed, closed by END
    task automatic put_frame(input int len, input bit specials_only);
        logic [BYTE_W-1:0] sym;
        for (int i = 0; i < len; i++)
        begin
            if (specials_only)
                sym = $urandom_range(1) ? SYM_END : SYM_ESC;
            else
                sym = 8'($urandom_range(255));
            if (sym == SYM_END)
            begin
                put_raw(SYM_ESC);
                put_raw(SYM_ESC_END);
            end
            else if (sym == SYM_ESC)
            begin
                put_raw(SYM_ESC);
                put_raw(SYM_ESC_ESC);
            end
            else
                put_raw(sym);
        end
        put_raw(SYM_END);
    endtask

    // stop sending and let the decoder run dry
    task automatic settle();
        if (rx_high)
        begin
            rx_if.valid <= 1'b0;
            rx_high = 1'b0;
        end
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata     <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int target;
        int eff;
        int pick;
        bit paused;
        paused = 1'b0;

        rx_if.valid      <= 1'b0;
        rx_if.rx_byte    <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.reg_index <= CFG_BUFFER_LIMIT;
        cfg_if.wdata     <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty frame, extremes, both escapes, escape codes as plain data
        put_raw(SYM_END);
        put_raw(8'h00);
        put_raw(8'hFF);
        put_raw(SYM_ESC);
        put_raw(SYM_ESC_END);
        put_raw(SYM_ESC);
        put_raw(SYM_ESC_ESC);
        put_raw(SYM_END);
        put_raw(SYM_ESC_END);
        put_raw(SYM_ESC_ESC);
        put_raw(SYM_END);
        // bad escape, byte dropped
        put_raw(SYM_ESC);
        put_raw(8'h41);
        put_raw(SYM_END);

        // tightest buffer, keep mode: overflow then END on the cleared frame
        settle();
        write_reg(CFG_BUFFER_LIMIT, LIMIT_MIN);
        write_reg(CFG_OVERFLOW_KEEPS, 7'd1);
        put_raw(8'h55);
        put_raw(SYM_END);
        put_raw(SYM_ESC);
        put_raw(8'h10);

        // drop mode with upper data bits set; unused indexes must be ignored
        settle();
        write_reg(CFG_BUFFER_LIMIT, 7'd3);
        write_reg(CFG_OVERFLOW_KEEPS, 7'h7E);
        write_reg(CFG_SPARE_A, 7'h7F);
        write_reg(CFG_SPARE_B, 7'h00);
        put_raw(8'h01);
        put_raw(8'h02);
        put_raw(SYM_END);
        put_raw(SYM_ESC);
        put_raw(SYM_ESC);
        put_raw(SYM_END);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_reg(CFG_BUFFER_LIMIT, phase_limit[p]);
            write_reg(CFG_OVERFLOW_KEEPS, {6'($urandom_range(63)), phase_keep[p]});
            quiet = (p == 1);
            eff   = int'(phase_limit[p]);
            if (eff > BUF_DEPTH_DEF)
                eff = BUF_DEPTH_DEF;
            if (eff < int'(LIMIT_MIN))
                eff = int'(LIMIT_MIN);

            // escape-only frame long enough to overflow a full buffer
            if (p == 0)
                put_frame(64, 1'b1);

            target = sent + PHASE_BEATS;
            while (sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    if ($urandom_range(9) == 0)
                        put_frame($urandom_range(eff + 3), $urandom_range(11) == 0);
                    else
                        put_frame($urandom_range(8), $urandom_range(11) == 0);
                end
                else if (pick < 88)
                begin
                    repeat ($urandom_range(1, 4))
                        put_raw(8'($urandom_range(255)));
                end
                else
                begin
                    put_raw(SYM_ESC);
                    put_raw(8'($urandom_range(255)));
                end

                if (p == 0 && !paused && sent >= target - PHASE_BEATS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        quiet = 1'b0;
        settle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hdl/sfd_pkg.sv
hdl/sfd_channels.sv
hdl/sfd_ctrl.sv
hdl/sfd_datapath.sv
hdl/slip_frame_decoder.sv
tb/sfd_result_checker.sv
tb/slip_frame_decoder_tb.sv
